// ----- hw/rtl/msptg_pkg.sv -----
// Shared types and constants for the multi-slot pulse train generator.
package msptg_pkg;

    localparam int SLOT_COUNT_DEF = 4;
    localparam int NUM_PINS_DEF   = 32;

    localparam int PIN_W   = 5;
    localparam int TIME_W  = 24;
    localparam int CNT_W   = 16;
    localparam int STEP_W  = 16;
    localparam int PHASE_W = 26;
    localparam int LVL_W   = 32;
    localparam int USED_W  = 2;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd1;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK_RD,
        S_TICK_ADD,
        S_TICK_WB,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [PIN_W-1:0]          pin;
        logic [TIME_W-1:0]         period;
        logic [TIME_W-1:0]         width;
        logic signed [PHASE_W-1:0] phase;
        logic [CNT_W-1:0]          remaining;
    } t_slot;

endpackage

// ----- hw/rtl/multi_slot_pulse_train_generator.sv -----
// Top level: slot memory, tick sequencer and pin level register.
//
//  channel | valid       | ready        | payload
//  --------+-------------+--------------+-------------------------------------------
//  in      | i_in_valid  | o_in_ready   | i_action i_pin_index i_period_us
//          |             |              | i_width_us i_pulse_count
//  out     | o_out_valid | i_out_ready  | o_accepted o_slot_used o_running o_pin_levels
//  cfg     | i_cfg_valid | o_cfg_ready  | i_cfg_data (tick step)
//
// A start item writes its slot entry at acceptance; it and a tick while stopped then go
// to S_OUT, where the result is loaded into the output register. A running tick walks
// every slot, with memory read, phase add and write back for an active one, then S_OUT.
// Reset clears the slot busy flags, the pin levels and the run flag at once; the
// slot memory itself is not cleared. The output register frees the block to take
// the next item while a result waits; a full output register stalls the sequencer.
module multi_slot_pulse_train_generator
    import msptg_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int NUM_PINS   = NUM_PINS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_action,
    input  logic [PIN_W-1:0]    i_pin_index,
    input  logic [TIME_W-1:0]   i_period_us,
    input  logic [TIME_W-1:0]   i_width_us,
    input  logic [CNT_W-1:0]    i_pulse_count,

    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_accepted,
    output logic [USED_W-1:0]   o_slot_used,
    output logic                o_running,
    output logic [LVL_W-1:0]    o_pin_levels,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [STEP_W-1:0]   i_cfg_data
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CMP_W  = PHASE_W + 1;

    // Slot memory
    t_slot mem_slot [SLOT_COUNT];

    t_state r_state, n_state;

    logic [STEP_W-1:0]          r_tick_step;
    logic [SLOT_COUNT-1:0]      r_active;
    logic [NUM_PINS-1:0]        r_pin_state, n_pin_state;
    logic                       r_engine_on;
    logic [SLOT_W-1:0]          r_slot;
    logic                       r_any;
    logic                       r_res_acc;
    logic [SLOT_W-1:0]          r_res_slot;

    t_slot                      r_rd;
    logic signed [PHASE_W-1:0]  r_phase_n;
    logic [CNT_W-1:0]           r_rem_n;
    logic [TIME_W:0]            r_wlim;

    logic                       r_out_valid;
    logic                       r_out_acc;
    logic [USED_W-1:0]          r_out_used;
    logic                       r_out_run;
    logic [LVL_W-1:0]           r_out_lvl;

    logic                       w_in_acc;
    logic                       w_start;
    logic                       w_found;
    logic [SLOT_W-1:0]          w_free;
    logic                       w_last;
    logic                       w_cur_active;
    logic                       w_rd_en;
    logic                       w_out_load;
    logic                       w_tick_done;
    logic                       w_keep;
    logic                       w_any_next;

    logic signed [PHASE_W-1:0]  w_step_x;
    logic signed [PHASE_W-1:0]  w_sum;
    logic                       w_wrap;
    logic signed [CMP_W-1:0]    w_ph_c;
    logic signed [CMP_W-1:0]    w_wid_c;
    logic signed [CMP_W-1:0]    w_lim_c;

    logic                       w_we;
    logic [SLOT_W-1:0]          w_waddr;
    t_slot                      w_wdata;

    logic                       w_drv_en;
    logic                       w_drv_lvl;
    logic [PIN_W-1:0]           w_drv_pin;

    // Handshakes
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_start     = w_in_acc && (i_action == ACT_START);
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    assign o_out_valid  = r_out_valid;
    assign o_accepted   = r_out_acc;
    assign o_slot_used  = r_out_used;
    assign o_running    = r_out_run;
    assign o_pin_levels = r_out_lvl;

    // Lowest free slot
    always_comb begin
        w_found = 1'b0;
        w_free  = '0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            if (!r_active[s]) begin
                w_found = 1'b1;
                w_free  = SLOT_W'(s);
            end
        end
    end

    assign w_last       = (r_slot == SLOT_W'(SLOT_COUNT - 1));
    assign w_cur_active = r_active[r_slot];
    assign w_rd_en      = (r_state == S_TICK_RD) && w_cur_active;

    // Phase arithmetic
    assign w_step_x = $signed({{(PHASE_W - STEP_W){1'b0}}, r_tick_step});
    assign w_sum    = r_rd.phase + w_step_x;
    assign w_wrap   = (w_sum >= $signed({{(PHASE_W - TIME_W){1'b0}}, r_rd.period}));
    assign w_ph_c   = CMP_W'(r_phase_n);
    assign w_wid_c  = $signed({{(CMP_W - TIME_W){1'b0}}, r_rd.width});
    assign w_lim_c  = $signed({{(CMP_W - TIME_W - 1){1'b0}}, r_wlim});

    assign w_keep      = (r_state == S_TICK_WB) && (r_rem_n != '0);
    assign w_any_next  = r_any || w_keep;
    assign w_tick_done = w_last && (((r_state == S_TICK_RD) && !w_cur_active)
                                    || (r_state == S_TICK_WB));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_action == ACT_START || !r_engine_on) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_TICK_RD;
                    end
                end
            end
            S_TICK_RD: begin
                if (w_cur_active) begin
                    n_state = S_TICK_ADD;
                end else if (w_last) begin
                    n_state = S_OUT;
                end
            end
            S_TICK_ADD: n_state = S_TICK_WB;
            S_TICK_WB:  n_state = w_last ? S_OUT : S_TICK_RD;
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Memory write port and pin drive
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_slot;
        w_wdata   = r_rd;
        w_drv_en  = 1'b0;
        w_drv_lvl = 1'b0;
        w_drv_pin = r_rd.pin;
        unique case (r_state)
            S_IDLE: begin
                w_waddr           = w_free;
                w_wdata.pin       = i_pin_index;
                w_wdata.period    = i_period_us;
                w_wdata.width     = i_width_us;
                w_wdata.phase     = -w_step_x;
                w_wdata.remaining = i_pulse_count;
                w_we              = w_start && w_found;
                w_drv_en          = w_start && w_found;
                w_drv_pin         = i_pin_index;
            end
            S_TICK_WB: begin
                w_we              = 1'b1;
                w_wdata.phase     = r_phase_n;
                w_wdata.remaining = r_rem_n;
                if (r_rem_n != '0) begin
                    if (r_phase_n == '0) begin
                        w_drv_en  = 1'b1;
                        w_drv_lvl = 1'b1;
                    end else if (w_ph_c >= w_wid_c && w_ph_c < w_lim_c) begin
                        w_drv_en  = 1'b1;
                    end
                end
            end
            S_TICK_RD, S_TICK_ADD, S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_pin_state = r_pin_state;
        for (int p = 0; p < NUM_PINS; p++) begin
            if (w_drv_en && int'(w_drv_pin) == p) begin
                n_pin_state[p] = w_drv_lvl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_slot[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd <= mem_slot[r_slot];
        end
    end

    // Phase add and wrap; hold results for write back
    always_ff @(posedge i_clk) begin
        if (r_state == S_TICK_ADD) begin
            r_phase_n <= w_wrap ? '0 : w_sum;
            r_rem_n   <= r_rd.remaining - CNT_W'(w_wrap);
            r_wlim    <= {1'b0, r_rd.width} + (TIME_W + 1)'(r_tick_step);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick_step <= STEP_RESET;
            r_active    <= '0;
            r_pin_state <= '0;
            r_engine_on <= 1'b0;
            r_slot      <= '0;
            r_any       <= 1'b0;
            r_res_acc   <= 1'b0;
            r_res_slot  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pin_state <= n_pin_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tick_step <= i_cfg_data;
            end
            if (w_in_acc) begin
                r_slot     <= '0;
                r_any      <= 1'b0;
                r_res_acc  <= w_start && w_found;
                r_res_slot <= (w_start && w_found) ? w_free : '0;
            end
            if (w_start && w_found) begin
                r_active[w_free] <= (i_pulse_count != '0);
                r_engine_on      <= 1'b1;
            end
            if (r_state == S_TICK_WB) begin
                r_active[r_slot] <= (r_rem_n != '0);
                r_any            <= w_any_next;
            end
            // advance to the next slot
            if (!w_last && (((r_state == S_TICK_RD) && !w_cur_active)
                            || (r_state == S_TICK_WB))) begin
                r_slot <= r_slot + 1'b1;
            end
            if (w_tick_done) begin
                r_engine_on <= w_any_next;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_acc  <= r_res_acc;
            r_out_used <= USED_W'(r_res_slot);
            r_out_run  <= r_engine_on;
            r_out_lvl  <= LVL_W'(r_pin_state);
        end
    end

endmodule

// ----- hw/rtl/msptg_checker.sv -----
// Port-level checker for the pulse train generator, bound to the top level.
module msptg_checker
    import msptg_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_accepted,
    input logic [USED_W-1:0] o_slot_used,
    input logic              o_running,
    input logic [LVL_W-1:0]  o_pin_levels
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic [1:0] r_pend;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // Items taken but whose result is not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(w_in_acc) - 2'(w_out_acc);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_accepted)
            && $stable(o_slot_used) && $stable(o_running) && $stable(o_pin_levels))
        else $error("result changed while stalled");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> r_pend != 2'd0)
        else $error("result without an item");

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("second item taken while one is in work");

    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_accepted |-> o_slot_used == '0)
        else $error("slot reported for a refused item");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> o_running)
        else $error("accepted start left the engine stopped");

endmodule

bind multi_slot_pulse_train_generator msptg_checker u_msptg_checker (.*);

// ----- tb/multi_slot_pulse_train_generator_tb.sv -----
// Self-checking bench for the multi-slot pulse train generator: directed cases, then random phases.
`timescale 1ns / 100ps

module multi_slot_pulse_train_generator_tb;
    import msptg_pkg::*;

    localparam int SLOTS           = SLOT_COUNT_DEF;
    localparam int ITEMS_PER_PHASE = 270;
    localparam int PHASES          = 7;
    localparam int LONG_HOLD       = 400;
    localparam int SETTLE_TAIL     = 20;
    localparam int SETTLE_LIMIT    = 5000;

    typedef struct packed {
        logic              action;
        logic [PIN_W-1:0]  pin;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] width;
        logic [CNT_W-1:0]  count;
    } t_request;

    typedef struct packed {
        logic              accepted;
        logic [USED_W-1:0] slot;
        logic              running;
        logic [LVL_W-1:0]  levels;
    } t_status;

    typedef struct packed {
        t_request req;
        logic     typed;
        t_status  want;
    } t_row;

    localparam t_request TICK_ONES = '{ACT_TICK, '1, '1, '1, '1};
    localparam t_request TICK_ZERO = '{ACT_TICK, '0, '0, '0, '0};
    localparam t_status  NO_CHECK  = '0;
    localparam int       DIR_ROWS  = 24;

    // The opening tick row and the start rows up to the refused one read straight off the slot
    // rules; the rest go through the train model.
    localparam t_row DIRECTED [0:DIR_ROWS-1] = '{
        '{TICK_ZERO, 1'b1, '{1'b0, 2'd0, 1'b0, 32'd0}},
        '{'{ACT_START, 5'd31, 24'd3, 24'd1, 16'd2}, 1'b1, '{1'b1, 2'd0, 1'b1, 32'd0}},
        '{'{ACT_START, 5'd0, 24'hFFFFFF, 24'hFFFFFF, 16'd0}, 1'b1, '{1'b1, 2'd1, 1'b1, 32'd0}},
        '{'{ACT_START, 5'd5, 24'd0, 24'd0, 16'd3}, 1'b1, '{1'b1, 2'd1, 1'b1, 32'd0}},
        '{'{ACT_START, 5'd31, 24'd2, 24'd1, 16'd2}, 1'b1, '{1'b1, 2'd2, 1'b1, 32'd0}},
        '{'{ACT_START, 5'd17, 24'd4, 24'd2, 16'd5}, 1'b1, '{1'b1, 2'd3, 1'b1, 32'd0}},
        '{'{ACT_START, 5'd31, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF}, 1'b1,
          '{1'b0, 2'd0, 1'b1, 32'd0}},
        '{TICK_ONES, 1'b0, NO_CHECK},
        '{TICK_ZERO, 1'b0, NO_CHECK},
        '{TICK_ONES, 1'b0, NO_CHECK},
        '{TICK_ZERO, 1'b0, NO_CHECK},
        '{TICK_ONES, 1'b0, NO_CHECK},
        '{TICK_ZERO, 1'b0, NO_CHECK},
        '{'{ACT_START, 5'd2, 24'd2, 24'd5, 16'd3}, 1'b0, NO_CHECK},
        '{TICK_ONES, 1'b0, NO_CHECK},
        '{TICK_ZERO, 1'b0, NO_CHECK},
        '{TICK_ONES, 1'b0, NO_CHECK},
        '{TICK_ZERO, 1'b0, NO_CHECK},
        '{TICK_ONES, 1'b0, NO_CHECK},
        '{TICK_ZERO, 1'b0, NO_CHECK},
        '{'{ACT_START, 5'd0, 24'd1, 24'd0, 16'd1}, 1'b0, NO_CHECK},
        '{TICK_ONES, 1'b0, NO_CHECK},
        '{TICK_ZERO, 1'b0, NO_CHECK},
        '{TICK_ONES, 1'b0, NO_CHECK}
    };

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                i_action      = ACT_TICK;
    logic [PIN_W-1:0]    i_pin_index   = '0;
    logic [TIME_W-1:0]   i_period_us   = '0;
    logic [TIME_W-1:0]   i_width_us    = '0;
    logic [CNT_W-1:0]    i_pulse_count = '0;
    logic                i_out_ready   = 1'b0;
    logic                i_cfg_valid   = 1'b0;
    logic [STEP_W-1:0]   i_cfg_data    = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_accepted;
    logic [USED_W-1:0]   o_slot_used;
    logic                o_running;
    logic [LVL_W-1:0]    o_pin_levels;
    logic                o_cfg_ready;

    // Train model state
    logic [PIN_W-1:0]    trn_pin    [SLOTS];
    longint              trn_period [SLOTS];
    longint              trn_width  [SLOTS];
    longint              trn_phase  [SLOTS];
    logic [CNT_W-1:0]    trn_left   [SLOTS];
    logic [LVL_W-1:0]    pin_lvl;
    logic                eng_on;
    longint              step_us;

    t_status status_due[$];
    int      mismatches = 0;
    int      feed_calm  = 0;
    int      sink_calm  = 0;

    multi_slot_pulse_train_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_pin_index   (i_pin_index),
        .i_period_us   (i_period_us),
        .i_width_us    (i_width_us),
        .i_pulse_count (i_pulse_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_accepted    (o_accepted),
        .o_slot_used   (o_slot_used),
        .o_running     (o_running),
        .o_pin_levels  (o_pin_levels),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one item to the train model and return the status it leaves behind.
    function automatic t_status advance_trains(t_request r);
        t_status res;
        logic    alive;
        res   = '0;
        alive = 1'b0;
        if (r.action == ACT_START) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (trn_left[s] == '0) begin
                    trn_pin[s]          = r.pin;
                    trn_period[s]       = longint'(r.period);
                    trn_width[s]        = longint'(r.width);
                    trn_left[s]         = r.count;
                    trn_phase[s]        = -step_us;
                    pin_lvl[r.pin]      = 1'b0;
                    eng_on              = 1'b1;
                    res.accepted        = 1'b1;
                    res.slot            = USED_W'(s);
                    break;
                end
            end
        end else if (eng_on) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (trn_left[s] != '0) begin
                    trn_phase[s] += step_us;
                    if (trn_phase[s] >= trn_period[s]) begin
                        trn_phase[s] = 0;
                        trn_left[s]  = trn_left[s] - 1'b1;
                    end
                    if (trn_left[s] != '0) begin
                        if (trn_phase[s] == 0)
                            pin_lvl[trn_pin[s]] = 1'b1;
                        else if (trn_phase[s] >= trn_width[s] &&
                                 trn_phase[s] < trn_width[s] + step_us)
                            pin_lvl[trn_pin[s]] = 1'b0;
                        alive = 1'b1;
                    end
                end
            end
            if (!alive)
                eng_on = 1'b0;
        end
        res.running = eng_on;
        res.levels  = pin_lvl;
        return res;
    endfunction

    // Mostly busy, with the odd quiet stretch of back-to-back items.
    function automatic int idle_draw(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    task automatic match_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic offer(input t_request r, input logic typed, input t_status typed_res);
        t_status guess;
        int      gap;
        gap = idle_draw(feed_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= r.action;
        i_pin_index   <= r.pin;
        i_period_us   <= r.period;
        i_width_us    <= r.width;
        i_pulse_count <= r.count;
        do @(posedge i_clk); while (!o_in_ready);
        guess = advance_trains(r);
        status_due.push_back(typed ? typed_res : guess);
    endtask

    // Drop valid, wait for every status to come back, then let the sequencer go quiet.
    task automatic settle();
        int spin;
        spin = 0;
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            spin++;
        end while (status_due.size() != 0 && spin < SETTLE_LIMIT);
        repeat (SETTLE_TAIL) @(posedge i_clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        step_us = longint'(v);
    endtask

    // Trains are sized in tick steps so that they finish within a few hundred ticks.
    task automatic draw_request(output t_request r);
        longint span;
        logic   full;
        full = 1'b1;
        foreach (trn_left[s])
            if (trn_left[s] == '0)
                full = 1'b0;
        r.action = ($urandom_range(0, 9) < 3) ? ACT_START : ACT_TICK;
        r.pin    = ($urandom_range(0, 2) == 0) ? PIN_W'($urandom) : PIN_W'($urandom_range(0, 3));
        r.period = TIME_W'($urandom);
        r.width  = TIME_W'($urandom);
        r.count  = CNT_W'($urandom);
        if (r.action == ACT_START && !full) begin
            if ($urandom_range(0, 15) == 0) begin
                // full-range period and width: keep the train short enough to finish
                r.count = (step_us >= 32768) ? CNT_W'(1) : CNT_W'(0);
            end else begin
                span = longint'($urandom_range(0, 8)) * step_us +
                       longint'($urandom_range(0, int'(step_us - 1)));
                r.period = TIME_W'(span);
                r.width  = TIME_W'($urandom_range(0, int'(span + step_us)));
                r.count  = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom_range(7, 20))
                                                       : CNT_W'($urandom_range(0, 6));
            end
        end
    endtask

    task automatic run_down();
        t_request r;
        while (eng_on) begin
            draw_request(r);
            r.action = ACT_TICK;
            offer(r, 1'b0, NO_CHECK);
        end
    endtask

    always @(posedge i_clk) begin : status_check
        t_status want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (status_due.size() == 0) begin
                $error("unexpected status item: accepted %0d slot %0d running %0d levels 0x%0h",
                       o_accepted, o_slot_used, o_running, o_pin_levels);
                mismatches++;
            end else begin
                want = status_due.pop_front();
                match_field("accepted", longint'(want.accepted), longint'(o_accepted));
                match_field("slot_used", longint'(want.slot), longint'(o_slot_used));
                match_field("running", longint'(want.running), longint'(o_running));
                match_field("pin_levels", longint'(want.levels), longint'(o_pin_levels));
            end
        end
    end

    initial begin : status_sink
        int pause;
        int taken;
        taken = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            // hold off twice for a long stretch so the block backs up into its input
            pause = (taken == 600 || taken == 1500) ? LONG_HOLD : idle_draw(sink_calm);
            if (pause > 0) begin
                i_out_ready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
        end
    end

    initial begin : stimulus
        t_request          req;
        logic [STEP_W-1:0] step_pick;
        logic              live;
        int                n_done;
        foreach (trn_left[s]) begin
            trn_left[s]   = '0;
            trn_pin[s]    = '0;
            trn_period[s] = 0;
            trn_width[s]  = 0;
            trn_phase[s]  = 0;
        end
        pin_lvl = '0;
        eng_on  = 1'b0;
        step_us = longint'(STEP_RESET);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++)
            offer(DIRECTED[k].req, DIRECTED[k].typed, DIRECTED[k].want);
        run_down();

        // zero count: slot stays free and the next tick stops the engine
        offer('{ACT_START, 5'd12, 24'd7, 24'd3, 16'd0}, 1'b0, NO_CHECK);
        offer(TICK_ZERO, 1'b0, NO_CHECK);
        offer(TICK_ONES, 1'b0, NO_CHECK);

        // zero tick step: phase never moves, so no width crossing
        settle();
        write_step('0);
        offer('{ACT_START, 5'd9, 24'd5, 24'd0, 16'd2}, 1'b0, NO_CHECK);
        offer('{ACT_START, 5'd10, 24'd0, 24'd3, 16'd2}, 1'b0, NO_CHECK);
        repeat (6) offer(TICK_ONES, 1'b0, NO_CHECK);
        settle();
        write_step('1);
        run_down();

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0, 4:    step_pick = STEP_W'(1);
                1, 6:    step_pick = '1;
                2:       step_pick = STEP_W'($urandom_range(2, 9));
                3:       step_pick = STEP_W'($urandom_range(10, 65534));
                default: step_pick = STEP_W'($urandom_range(2, 300));
            endcase
            write_step(step_pick);
            n_done = 0;
            while (n_done < ITEMS_PER_PHASE) begin
                draw_request(req);
                live = eng_on || req.action == ACT_START;
                offer(req, 1'b0, NO_CHECK);
                if (live)
                    n_done++;
            end
            run_down();
        end

        settle();
        if (status_due.size() != 0) begin
            $error("%0d status items never arrived", status_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("multi_slot_pulse_train_generator regression: pass");
        else
            $display("multi_slot_pulse_train_generator regression: fail");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("multi_slot_pulse_train_generator regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/msptg_pkg.sv
hw/rtl/multi_slot_pulse_train_generator.sv
hw/rtl/msptg_checker.sv
tb/multi_slot_pulse_train_generator_tb.sv
